### rtl/core/dshot_frame_transmitter_top_defines.svh
// assertion macros for the dshot frame transmitter
// used by dshot_frame_transmitter_top, expects clk and rst_n in scope
`ifndef DSHOT_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define DSHOT_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DSHOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSHOT_ASSERT_NEVER(lbl, cond, msg) \
    `DSHOT_ASSERT(lbl, !(cond), msg)
`else
`define DSHOT_ASSERT(lbl, prop, msg)
`define DSHOT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/dshot_pkg.sv
// shared types, constants and frame builder for the dshot frame transmitter
// no dependencies
package dshot_pkg;

    localparam int FRAME_SLOTS_DEF   = 18;
    localparam int COMPARE_WIDTH_DEF = 16;
    localparam int DATA_SLOTS        = 16;
    localparam int PW_W              = 16;
    localparam int THR_W             = 11;
    localparam int CNT_W             = 32;
    localparam int CFG_IDX_W         = 2;

    localparam logic [PW_W-1:0] ONE_PW_RESET  = 16'd420;
    localparam logic [PW_W-1:0] ZERO_PW_RESET = 16'd210;
    localparam logic [3:0]      NIBBLE_MASK   = 4'hF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TELEM   = 2'd2;

    typedef struct packed {
        logic             action;
        logic [THR_W-1:0] throttle;
    } item_t;

    typedef struct packed {
        logic [PW_W-1:0]  compare_value;
        logic             accepted;
        logic             skipped;
        logic             frame_done;
        logic             busy_flag;
        logic [CNT_W-1:0] frames_started;
        logic [CNT_W-1:0] frames_finished;
        logic [CNT_W-1:0] sends_skipped;
    } result_t;

    typedef struct packed {
        logic [PW_W-1:0] one_pw;
        logic [PW_W-1:0] zero_pw;
        logic            telem;
    } cfg_t;

    // throttle, telemetry bit, then xor of the three nibbles of those twelve bits
    function automatic logic [15:0] build_frame(input logic [THR_W-1:0] thr,
                                                input logic telem);
        logic [11:0] v;
        logic [3:0]  crc;
        v   = {thr, telem};
        crc = (v[3:0] ^ v[7:4] ^ v[11:8]) & NIBBLE_MASK;
        return {v, crc};
    endfunction

endpackage

### rtl/core/dshot_seq.sv
// frame state, slot sequencer and event counters
// depends on dshot_pkg
module dshot_seq #(
    parameter int FRAME_SLOTS   = dshot_pkg::FRAME_SLOTS_DEF,
    parameter int COMPARE_WIDTH = dshot_pkg::COMPARE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  dshot_pkg::item_t   item,
    input  dshot_pkg::cfg_t    cfg,
    output dshot_pkg::result_t res
);
    import dshot_pkg::*;

    localparam int SLOT_W = $clog2(FRAME_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [SLOT_W-1:0] DATA_END  = SLOT_W'(DATA_SLOTS);
    localparam logic [PW_W-1:0] CMP_MASK = (COMPARE_WIDTH >= PW_W) ? {PW_W{1'b1}} :
        PW_W'((64'd1 << COMPARE_WIDTH) - 64'd1);

    logic              busy_reg, busy_next;
    logic [15:0]       frame_reg, frame_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  started_reg, started_next;
    logic [CNT_W-1:0]  finished_reg, finished_next;
    logic [CNT_W-1:0]  skip_reg, skip_next;

    always_comb
    begin
        busy_next     = busy_reg;
        frame_next    = frame_reg;
        slot_next     = slot_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        skip_next     = skip_reg;
        res           = '0;
        if (!item.action)
        begin
            if (busy_reg)
            begin
                skip_next   = skip_reg + 32'd1;
                res.skipped = 1'b1;
            end
            else
            begin
                busy_next    = 1'b1;
                started_next = started_reg + 32'd1;
                frame_next   = build_frame(item.throttle, cfg.telem);
                slot_next    = '0;
                res.accepted = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // msb of the shift register is the current data bit
            if (slot_reg < DATA_END)
            begin
                res.compare_value = (frame_reg[15] ? cfg.one_pw : cfg.zero_pw) & CMP_MASK;
                frame_next        = {frame_reg[14:0], 1'b0};
            end
            if (slot_reg == LAST_SLOT)
            begin
                res.frame_done = 1'b1;
                finished_next  = finished_reg + 32'd1;
                busy_next      = 1'b0;
                slot_next      = '0;
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
        res.busy_flag       = busy_next;
        res.frames_started  = started_next;
        res.frames_finished = finished_next;
        res.sends_skipped   = skip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            frame_reg    <= '0;
            slot_reg     <= '0;
            started_reg  <= '0;
            finished_reg <= '0;
            skip_reg     <= '0;
        end
        else if (step)
        begin
            busy_reg     <= busy_next;
            frame_reg    <= frame_next;
            slot_reg     <= slot_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            skip_reg     <= skip_next;
        end
    end

endmodule

### rtl/core/dshot_frame_transmitter_top.sv
// dshot frame transmitter top: config registers, sequencer, result register
// the result of each item beat is registered and valid in the next cycle, one result per item
// throughput: one item per cycle, limited only by the result register draining
// reset: async active low, clears frame state, counters, result valid, and
//   restores pulse widths 420/210 and telemetry bit 0
module dshot_frame_transmitter_top #(
    parameter int FRAME_SLOTS   = dshot_pkg::FRAME_SLOTS_DEF,
    parameter int COMPARE_WIDTH = dshot_pkg::COMPARE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               item_valid,
    output logic                               item_ready,
    input  dshot_pkg::item_t                   item,
    // result channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output dshot_pkg::result_t                 result,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dshot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dshot_pkg::PW_W-1:0]         cfg_data
);
    import dshot_pkg::*;

`include "dshot_frame_transmitter_top_defines.svh"

    cfg_t    cfg_reg;
    result_t res_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    step;

    // config writes are always accepted and registered
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_pw  <= ONE_PW_RESET;
            cfg_reg.zero_pw <= ZERO_PW_RESET;
            cfg_reg.telem   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ONE_PW:  cfg_reg.one_pw  <= cfg_data;
                CFG_ZERO_PW: cfg_reg.zero_pw <= cfg_data;
                CFG_TELEM:   cfg_reg.telem   <= cfg_data[0];
                default:     ; // unused index, write dropped
            endcase
        end
    end

    // take a new item whenever the result register is empty or draining
    assign item_ready = !result_valid_reg || result_ready;
    assign step       = item_valid && item_ready;

    // all sequencer state advances on the item beat, the result lands next to it
    dshot_seq #(
        .FRAME_SLOTS   (FRAME_SLOTS),
        .COMPARE_WIDTH (COMPARE_WIDTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    // result register, holds while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `DSHOT_ASSERT(a_beat_gives_result, step |=> result_valid_reg, "item beat without result")
    `DSHOT_ASSERT_NEVER(a_acc_and_skip, result_valid_reg && result_reg.accepted && result_reg.skipped, "send both accepted and skipped")
    `DSHOT_ASSERT(a_busy_matches_counts, result_valid_reg |-> ((result_reg.frames_started - result_reg.frames_finished) == CNT_W'(result_reg.busy_flag)), "frame counts disagree with busy")
    `DSHOT_ASSERT(a_stall_only_when_full, !item_ready |-> (result_valid_reg && !result_ready), "item stalled with room for a result")

endmodule
